// ===== rtl/subpixel_threshold_extent_tracker_defines.svh =====
// Assertion macros for the RTL file that checks its own logic.
`ifndef SUBPIXEL_THRESHOLD_EXTENT_TRACKER_DEFINES_SVH
`define SUBPIXEL_THRESHOLD_EXTENT_TRACKER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define STET_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define STET_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stet_pkg.sv =====
package stet_pkg;

    localparam int GRID_SIZE = 1024;
    localparam int FRAC_BITS = 8;

    localparam int IDX_W  = $clog2(GRID_SIZE);
    localparam int INT_W  = IDX_W + 1;
    localparam int POS_W  = IDX_W + FRAC_BITS + 2;
    localparam int HGT_W  = 16;
    localparam int FRC_W  = FRAC_BITS + 1;
    localparam int STEP_W = $clog2(FRAC_BITS);

    localparam logic [INT_W-1:0] INT_MIN_RESET = INT_W'(GRID_SIZE);
    localparam logic signed [POS_W-1:0] POS_MIN_RESET = POS_W'(GRID_SIZE) << FRAC_BITS;
    localparam logic signed [POS_W-1:0] FX_ONE = POS_W'(1) << FRAC_BITS;
    localparam logic [FRC_W-1:0] FRC_ONE  = FRC_W'(1) << FRAC_BITS;
    localparam logic [FRC_W-1:0] FRC_HALF = FRC_W'(1) << (FRAC_BITS - 1);

    // Queue depth must be a power of two so the pointers wrap on their own.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Crossing lanes.
    localparam int NLANE   = 4;
    localparam int LN_CMIN = 0;
    localparam int LN_CMAX = 1;
    localparam int LN_RMIN = 2;
    localparam int LN_RMAX = 3;

    typedef enum logic [1:0] {
        XK_HALF,
        XK_ZERO,
        XK_ONE,
        XK_DIV
    } t_xkind;

    typedef struct packed {
        t_xkind           kind;
        logic [HGT_W-1:0] num;
        logic [HGT_W-1:0] den;
    } t_xing;

    typedef struct packed {
        logic [IDX_W-1:0]    col;
        logic [IDX_W-1:0]    row;
        logic                above;
        logic                last;
        t_xing [NLANE-1:0]   xing;
    } t_qent;

    typedef struct packed {
        logic signed [POS_W-1:0] x_lo;
        logic signed [POS_W-1:0] x_hi;
        logic signed [POS_W-1:0] y_lo;
        logic signed [POS_W-1:0] y_hi;
        logic [INT_W-1:0]        center_col;
        logic [INT_W-1:0]        center_row;
        logic                    x_swapped;
        logic                    y_swapped;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_UPDATE,
        S_EMIT
    } t_bstate;

endpackage

// ===== rtl/stet_front.sv =====
module stet_front
    import stet_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [HGT_W-1:0] i_cfg_data,
    input  logic [IDX_W-1:0] i_col,
    input  logic [IDX_W-1:0] i_row,
    input  logic [HGT_W-1:0] i_h_center,
    input  logic [HGT_W-1:0] i_h_left,
    input  logic [HGT_W-1:0] i_h_right,
    input  logic [HGT_W-1:0] i_h_below,
    input  logic [HGT_W-1:0] i_h_above,
    input  logic             i_frame_end,
    output t_qent            o_entry
);

    logic [HGT_W-1:0] r_thr;

    // Sorts a crossing between a lower and an upper height into the cases
    // that need no division and the one that does.
    function automatic t_xing classify(input logic [HGT_W-1:0] lo,
                                       input logic [HGT_W-1:0] hi,
                                       input logic [HGT_W-1:0] thr);
        t_xing x;
        x.num = thr - lo;
        x.den = hi - lo;
        if (hi <= lo) begin
            x.kind = XK_HALF;
        end else if (thr <= lo) begin
            x.kind = XK_ZERO;
        end else if (thr >= hi) begin
            x.kind = XK_ONE;
        end else begin
            x.kind = XK_DIV;
        end
        return x;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    always_comb begin
        o_entry                = '0;
        o_entry.col            = i_col;
        o_entry.row            = i_row;
        o_entry.above          = i_h_center > r_thr;
        o_entry.last           = i_frame_end;
        o_entry.xing[LN_CMIN]  = classify(i_h_left, i_h_center, r_thr);
        o_entry.xing[LN_CMAX]  = classify(i_h_center, i_h_right, r_thr);
        o_entry.xing[LN_RMIN]  = classify(i_h_below, i_h_center, r_thr);
        o_entry.xing[LN_RMAX]  = classify(i_h_center, i_h_above, r_thr);
    end

endmodule

// ===== rtl/stet_fifo.sv =====
module stet_fifo
    import stet_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_qent i_data,
    output logic  o_full,
    input  logic  i_rd,
    output t_qent o_data,
    output logic  o_empty
);

    t_qent             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = r_count == (QPTR_W+1)'(QDEPTH);
    assign o_empty = r_count == '0;
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/stet_back.sv =====
`include "subpixel_threshold_extent_tracker_defines.svh"

module stet_back
    import stet_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qent   i_q_data,
    input  logic    i_q_empty,
    output logic    o_q_pop,
    input  logic    i_res_pop,
    output logic    o_res_empty,
    output t_result o_res
);

    t_bstate r_state;
    t_bstate n_state;

    t_qent                   r_ent;
    logic [HGT_W-1:0]        r_rem [NLANE];
    logic [FRAC_BITS-1:0]    r_quo [NLANE];
    logic [HGT_W-1:0]        n_rem [NLANE];
    logic [FRAC_BITS-1:0]    n_quo [NLANE];
    logic [STEP_W-1:0]       r_step;

    logic [INT_W-1:0]        r_cmin_int;
    logic [INT_W-1:0]        r_cmax_int;
    logic [INT_W-1:0]        r_rmin_int;
    logic [INT_W-1:0]        r_rmax_int;
    logic signed [POS_W-1:0] r_cmin_f;
    logic signed [POS_W-1:0] r_cmax_f;
    logic signed [POS_W-1:0] r_rmin_f;
    logic signed [POS_W-1:0] r_rmax_f;

    t_result                 r_out;
    logic                    r_out_valid;

    logic                    out_free;
    logic                    div_done;
    logic                    ld_entry;
    logic                    run_div;
    logic                    do_update;
    logic                    do_emit;
    logic                    rem_ok;

    logic [FRC_W-1:0]        frc [NLANE];
    logic [INT_W-1:0]        col_i;
    logic [INT_W-1:0]        row_i;
    logic signed [POS_W-1:0] cand_cmin;
    logic signed [POS_W-1:0] cand_cmax;
    logic signed [POS_W-1:0] cand_rmin;
    logic signed [POS_W-1:0] cand_rmax;
    logic [INT_W:0]          csum;
    logic [INT_W:0]          rsum;
    t_result                 res;

    function automatic logic signed [POS_W-1:0] pos_of(input logic [IDX_W-1:0] idx,
                                                       input logic [FRC_W-1:0] f);
        logic signed [POS_W-1:0] base;
        base = $signed({{(POS_W-IDX_W-FRAC_BITS){1'b0}}, idx, {FRAC_BITS{1'b0}}});
        return base + $signed({{(POS_W-FRC_W){1'b0}}, f});
    endfunction

    assign out_free    = !r_out_valid || i_res_pop;
    assign div_done    = r_step == STEP_W'(FRAC_BITS - 1);
    assign o_res_empty = !r_out_valid;
    assign o_res       = r_out;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_data.above) begin
                        n_state = S_DIV;
                    end else if (i_q_data.last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = r_ent.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        ld_entry  = 1'b0;
        run_div   = 1'b0;
        do_update = 1'b0;
        do_emit   = 1'b0;
        unique case (r_state)
            S_IDLE:   ld_entry  = !i_q_empty;
            S_DIV:    run_div   = 1'b1;
            S_UPDATE: do_update = 1'b1;
            S_EMIT:   do_emit   = out_free;
            default:  ld_entry  = 1'b0;
        endcase
    end

    assign o_q_pop = ld_entry;

    // One restoring division step per lane. For a lane that needs a division
    // the numerator is below the divisor, so the quotient has only fraction bits.
    always_comb begin
        logic [HGT_W:0] t;
        for (int k = 0; k < NLANE; k++) begin
            t = {r_rem[k], 1'b0};
            if (t >= {1'b0, r_ent.xing[k].den}) begin
                n_rem[k] = HGT_W'(t - {1'b0, r_ent.xing[k].den});
                n_quo[k] = {r_quo[k][FRAC_BITS-2:0], 1'b1};
            end else begin
                n_rem[k] = t[HGT_W-1:0];
                n_quo[k] = {r_quo[k][FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        rem_ok = 1'b1;
        for (int k = 0; k < NLANE; k++) begin
            if (r_ent.xing[k].kind == XK_DIV && r_rem[k] >= r_ent.xing[k].den) begin
                rem_ok = 1'b0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NLANE; k++) begin
            case (r_ent.xing[k].kind)
                XK_HALF: frc[k] = FRC_HALF;
                XK_ZERO: frc[k] = '0;
                XK_ONE:  frc[k] = FRC_ONE;
                default: frc[k] = {1'b0, r_quo[k]};
            endcase
        end
    end

    assign col_i     = {1'b0, r_ent.col};
    assign row_i     = {1'b0, r_ent.row};
    assign cand_cmin = pos_of(r_ent.col, frc[LN_CMIN]) - FX_ONE;
    assign cand_cmax = pos_of(r_ent.col, frc[LN_CMAX]);
    assign cand_rmin = pos_of(r_ent.row, frc[LN_RMIN]) - FX_ONE;
    assign cand_rmax = pos_of(r_ent.row, frc[LN_RMAX]);

    // An empty or inverted extent comes out ordered, with its flag set.
    always_comb begin
        csum           = {1'b0, r_cmin_int} + {1'b0, r_cmax_int};
        rsum           = {1'b0, r_rmin_int} + {1'b0, r_rmax_int};
        res.x_swapped  = r_cmin_f > r_cmax_f;
        res.y_swapped  = r_rmin_f > r_rmax_f;
        res.x_lo       = res.x_swapped ? r_cmax_f : r_cmin_f;
        res.x_hi       = res.x_swapped ? r_cmin_f : r_cmax_f;
        res.y_lo       = res.y_swapped ? r_rmax_f : r_rmin_f;
        res.y_hi       = res.y_swapped ? r_rmin_f : r_rmax_f;
        res.center_col = csum[INT_W:1];
        res.center_row = rsum[INT_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (ld_entry) begin
            r_ent <= i_q_data;
            for (int k = 0; k < NLANE; k++) begin
                r_rem[k] <= i_q_data.xing[k].num;
                r_quo[k] <= '0;
            end
        end else if (run_div) begin
            for (int k = 0; k < NLANE; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
        end
        if (do_emit) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_cmin_int  <= INT_MIN_RESET;
            r_rmin_int  <= INT_MIN_RESET;
            r_cmax_int  <= '0;
            r_rmax_int  <= '0;
            r_cmin_f    <= POS_MIN_RESET;
            r_rmin_f    <= POS_MIN_RESET;
            r_cmax_f    <= '0;
            r_rmax_f    <= '0;
        end else begin
            r_state <= n_state;
            if (run_div) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
            if (do_emit) begin
                r_cmin_int <= INT_MIN_RESET;
                r_rmin_int <= INT_MIN_RESET;
                r_cmax_int <= '0;
                r_rmax_int <= '0;
                r_cmin_f   <= POS_MIN_RESET;
                r_rmin_f   <= POS_MIN_RESET;
                r_cmax_f   <= '0;
                r_rmax_f   <= '0;
            end else if (do_update) begin
                if (col_i <= r_cmin_int) begin
                    r_cmin_int <= col_i;
                    if (r_cmin_f > cand_cmin) begin
                        r_cmin_f <= cand_cmin;
                    end
                end
                if (col_i >= r_cmax_int) begin
                    r_cmax_int <= col_i;
                    if (r_cmax_f < cand_cmax) begin
                        r_cmax_f <= cand_cmax;
                    end
                end
                if (row_i <= r_rmin_int) begin
                    r_rmin_int <= row_i;
                    if (r_rmin_f > cand_rmin) begin
                        r_rmin_f <= cand_rmin;
                    end
                end
                if (row_i >= r_rmax_int) begin
                    r_rmax_int <= row_i;
                    if (r_rmax_f < cand_rmax) begin
                        r_rmax_f <= cand_rmax;
                    end
                end
            end
        end
    end

    `STET_ASSERT_IMP(a_rem_below_den, i_clk, i_rst_n, r_state == S_DIV, rem_ok, "divider remainder reached its divisor")
    `STET_ASSERT_NXT(a_rearm_after_emit, i_clk, i_rst_n, do_emit, r_out_valid && r_cmin_int == INT_MIN_RESET && r_rmax_f == '0, "tracking state not rearmed after a result")
    `STET_ASSERT_IMP(a_result_ordered, i_clk, i_rst_n, r_out_valid, r_out.x_lo <= r_out.x_hi && r_out.y_lo <= r_out.y_hi, "result extents are not ordered")

endmodule

// ===== rtl/subpixel_threshold_extent_tracker.sv =====
// Tracks the extent of the region whose height lies above the threshold,
// one raster pixel with its four neighbors per item, and delivers one result
// with sub-pixel extents (8 fraction bits) and integer centers on the item
// that ends a frame, after which the tracking state starts over. Items enter
// a two-entry queue that takes up to one item per cycle while not full.
// Behind it the tracker finishes one item before it pops the next: a pixel
// at or below the threshold is only popped, and a pixel above it is loaded,
// run through the four radix-2 crossing dividers that run side by side, and
// used in an update; a frame end then hands over the result, which waits
// while the output register is full. A finished result is held there until
// popped, and the queue keeps accepting items meanwhile until it is full.
// The threshold register takes a write in any cycle and is meant to change
// only while the block is idle.
module subpixel_threshold_extent_tracker
    import stet_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [HGT_W-1:0]        i_cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [IDX_W-1:0]        i_col,
    input  logic [IDX_W-1:0]        i_row,
    input  logic [HGT_W-1:0]        i_h_center,
    input  logic [HGT_W-1:0]        i_h_left,
    input  logic [HGT_W-1:0]        i_h_right,
    input  logic [HGT_W-1:0]        i_h_below,
    input  logic [HGT_W-1:0]        i_h_above,
    input  logic                    i_frame_end,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [POS_W-1:0] o_x_lo,
    output logic signed [POS_W-1:0] o_x_hi,
    output logic signed [POS_W-1:0] o_y_lo,
    output logic signed [POS_W-1:0] o_y_hi,
    output logic [INT_W-1:0]        o_center_col,
    output logic [INT_W-1:0]        o_center_row,
    output logic                    o_x_swapped,
    output logic                    o_y_swapped
);

    t_qent   entry;
    t_qent   q_data;
    logic    q_empty;
    logic    q_pop;
    t_result res;

    stet_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_h_center  (i_h_center),
        .i_h_left    (i_h_left),
        .i_h_right   (i_h_right),
        .i_h_below   (i_h_below),
        .i_h_above   (i_h_above),
        .i_frame_end (i_frame_end),
        .o_entry     (entry)
    );

    stet_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (entry),
        .o_full  (full),
        .i_rd    (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    stet_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (q_data),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_res_pop   (pop),
        .o_res_empty (empty),
        .o_res       (res)
    );

    assign o_x_lo       = res.x_lo;
    assign o_x_hi       = res.x_hi;
    assign o_y_lo       = res.y_lo;
    assign o_y_hi       = res.y_hi;
    assign o_center_col = res.center_col;
    assign o_center_row = res.center_row;
    assign o_x_swapped  = res.x_swapped;
    assign o_y_swapped  = res.y_swapped;

endmodule
